>>> hdl/delimiter_tokenizer_macros.svh
// Assertion helpers for the delimiter tokenizer.
// Both sample on clk and are switched off while rst is high.
`ifndef DELIMITER_TOKENIZER_MACROS_SVH
`define DELIMITER_TOKENIZER_MACROS_SVH

// Same-cycle implication.
`define DLT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define DLT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/dlt_pkg.sv
package dlt_pkg;

  localparam int MAX_TOKEN   = 256;
  localparam int MAX_DELIMS  = 8;
  localparam int TOKEN_LEN_W = $clog2(MAX_TOKEN + 1);
  localparam int LINE_W      = 32;
  localparam int DSET_W      = 64;
  localparam int DCOUNT_W    = 3;
  localparam int CFG_IDX_W   = 2;

  localparam logic [7:0] CHR_NUL  = 8'd0;
  localparam logic [7:0] CHR_LF   = 8'd10;
  localparam logic [7:0] CHR_CR   = 8'd13;
  localparam logic [7:0] CHR_UC_A = 8'h41;
  localparam logic [7:0] CHR_UC_Z = 8'h5A;
  localparam logic [7:0] CHR_LC_A = 8'h61;
  localparam logic [7:0] CHR_LC_Z = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'd32;

  typedef enum logic [1:0] {
    ACT_DATA  = 2'd0,
    ACT_END   = 2'd1,
    ACT_ERROR = 2'd2,
    ACT_SKIP  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_READ_ERR = 2'd2,
    ST_ENDED    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CASE_KEEP  = 2'd0,
    CASE_UPPER = 2'd1,
    CASE_LOWER = 2'd2,
    CASE_KEEP2 = 2'd3
  } case_mode_t;

  typedef enum logic [1:0] {
    SKIP_IDLE  = 2'd0,
    SKIP_CRLF  = 2'd1,
    SKIP_LINE  = 2'd2,
    SKIP_DELIM = 2'd3
  } skip_phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELIM_SET   = 2'd0,
    REG_DELIM_COUNT = 2'd1,
    REG_CASE_MODE   = 2'd2,
    REG_UNUSED      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [DSET_W-1:0]   delimiter_set;
    logic [DCOUNT_W-1:0] delimiter_count;
    case_mode_t          case_mode;
  } cfg_t;

  typedef struct packed {
    logic       is_delim;
    logic       is_nl;
    logic       is_lf;
    logic [7:0] folded;
  } class_t;

  typedef struct packed {
    logic              char_valid;
    logic [7:0]        token_char;
    logic              token_last;
    logic [LINE_W-1:0] line_number;
    status_t           status;
  } result_t;

endpackage

>>> hdl/dlt_classify.sv
module dlt_classify
  import dlt_pkg::*;
(
  input  logic [7:0] data_byte,
  input  cfg_t       cfg,
  output class_t     cls
);

  logic       hit;
  logic [7:0] folded;

  // Compare against each packed delimiter lane in use.
  always_comb begin
    hit = (data_byte == CHR_NUL) || (data_byte == CHR_LF) || (data_byte == CHR_CR);
    for (int i = 0; i < MAX_DELIMS; i++) begin
      if ((i < int'(cfg.delimiter_count)) && (cfg.delimiter_set[8*i +: 8] == data_byte)) begin
        hit = 1'b1;
      end
    end
  end

  always_comb begin
    folded = data_byte;
    case (cfg.case_mode)
      CASE_UPPER: begin
        if (data_byte >= CHR_LC_A && data_byte <= CHR_LC_Z) folded = data_byte - CASE_GAP;
      end
      CASE_LOWER: begin
        if (data_byte >= CHR_UC_A && data_byte <= CHR_UC_Z) folded = data_byte + CASE_GAP;
      end
      default: folded = data_byte;
    endcase
  end

  assign cls.is_delim = hit;
  assign cls.is_nl    = (data_byte == CHR_LF) || (data_byte == CHR_CR);
  assign cls.is_lf    = (data_byte == CHR_LF);
  assign cls.folded   = folded;

endmodule

>>> hdl/dlt_step.sv
module dlt_step
  import dlt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  action_t action,
  input  class_t  cls,
  output logic    res_valid,
  output result_t res
);

  logic [7:0]             held_char, held_char_next;
  logic                   held_valid, held_valid_next;
  logic [TOKEN_LEN_W-1:0] token_length, token_length_next;
  logic [LINE_W-1:0]      line_count, line_count_next;
  logic                   line_pending, line_pending_next;
  logic                   skip_delay, skip_delay_next;
  skip_phase_t            skip_phase, skip_phase_next;
  logic                   stream_done, stream_done_next;
  logic                   had_token, had_token_next;

  logic              full;
  logic [1:0]        line_add;
  logic [LINE_W:0]   line_sum;

  assign full = token_length >= TOKEN_LEN_W'(MAX_TOKEN);

  // Next state.
  always_comb begin
    held_char_next    = held_char;
    held_valid_next   = held_valid;
    token_length_next = token_length;
    line_pending_next = line_pending;
    skip_delay_next   = skip_delay;
    skip_phase_next   = skip_phase;
    stream_done_next  = stream_done;
    had_token_next    = had_token;
    line_add          = 2'd0;
    if (!stream_done) begin
      case (action)
        ACT_END, ACT_ERROR: begin
          held_valid_next   = 1'b0;
          token_length_next = '0;
          stream_done_next  = 1'b1;
        end
        ACT_SKIP: begin
          held_valid_next   = 1'b0;
          token_length_next = '0;
          if (skip_phase == SKIP_IDLE) begin
            if (line_pending && !skip_delay) skip_delay_next = 1'b1;
            else skip_phase_next = SKIP_CRLF;
          end
        end
        default: begin
          case (skip_phase)
            SKIP_CRLF: begin
              if (!cls.is_nl) skip_phase_next = SKIP_LINE;
            end
            SKIP_LINE: begin
              if (cls.is_nl) skip_phase_next = SKIP_DELIM;
            end
            SKIP_DELIM: begin
              if (!cls.is_delim) begin
                skip_phase_next   = SKIP_IDLE;
                line_add          = line_pending ? 2'd2 : 2'd1;
                line_pending_next = 1'b0;
                skip_delay_next   = 1'b0;
                had_token_next    = 1'b1;
                held_char_next    = cls.folded;
                held_valid_next   = 1'b1;
                token_length_next = TOKEN_LEN_W'(1);
              end
            end
            default: begin
              if (cls.is_delim) begin
                held_valid_next   = 1'b0;
                token_length_next = '0;
                if (cls.is_lf) begin
                  if (held_valid || had_token) line_pending_next = 1'b1;
                  else line_add = 2'd1;
                end
              end else if (held_valid && !full) begin
                held_char_next    = cls.folded;
                token_length_next = token_length + TOKEN_LEN_W'(1);
              end else begin
                // Start a new token (also after an overlong cut).
                line_add          = line_pending ? 2'd1 : 2'd0;
                line_pending_next = 1'b0;
                skip_delay_next   = 1'b0;
                had_token_next    = 1'b1;
                held_char_next    = cls.folded;
                held_valid_next   = 1'b1;
                token_length_next = TOKEN_LEN_W'(1);
              end
            end
          endcase
        end
      endcase
    end
  end

  assign line_sum        = {1'b0, line_count} + (LINE_W + 1)'(line_add);
  assign line_count_next = line_sum[LINE_W] ? '1 : line_sum[LINE_W-1:0];

  // Result of this word.
  always_comb begin
    res_valid       = 1'b0;
    res.char_valid  = held_valid;
    res.token_char  = held_valid ? held_char : 8'd0;
    res.token_last  = held_valid;
    res.line_number = line_count;
    res.status      = full ? ST_TOO_LONG : ST_OK;
    if (!stream_done) begin
      case (action)
        ACT_END: begin
          res_valid  = 1'b1;
          res.status = ST_ENDED;
        end
        ACT_ERROR: begin
          res_valid  = 1'b1;
          res.status = ST_READ_ERR;
        end
        ACT_SKIP: begin
          res_valid = held_valid;
        end
        default: begin
          if (skip_phase == SKIP_IDLE && held_valid) begin
            res_valid      = 1'b1;
            res.token_last = cls.is_delim || full;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid   <= 1'b0;
      token_length <= '0;
      line_count   <= LINE_W'(1);
      line_pending <= 1'b0;
      skip_delay   <= 1'b0;
      skip_phase   <= SKIP_IDLE;
      stream_done  <= 1'b0;
      had_token    <= 1'b0;
    end else if (advance) begin
      held_valid   <= held_valid_next;
      token_length <= token_length_next;
      line_count   <= line_count_next;
      line_pending <= line_pending_next;
      skip_delay   <= skip_delay_next;
      skip_phase   <= skip_phase_next;
      stream_done  <= stream_done_next;
      had_token    <= had_token_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      held_char <= held_char_next;
    end
  end

endmodule

>>> hdl/delimiter_tokenizer.sv
// Delimiter tokenizer: takes one word per cycle (a data byte, end of input,
// read error or skip-rest-of-line request) and splits the byte stream into
// tokens. A token byte is folded to case on arrival, held, and emitted when
// the next word comes in, with token_last set on the final byte of a token
// and a saturating line number that counts deferred line ends. Sustained
// rate is one word per clock while out_ready is high. The accepting edge
// loads the input register; the result register is loaded from it, through
// the tokenizer step logic, once that register is empty or being drained.
// Words that produce no result still wait for a free result slot to step.
// After end of input or a read error the block swallows every word until
// reset. Configuration writes via cfg_write/cfg_index/cfg_data must be made
// only while the block is idle; the block itself does not enforce this.
module delimiter_tokenizer
  import dlt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Configuration
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DSET_W-1:0]     cfg_data,
  // Input words
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            action,
  input  logic [7:0]            data_byte,
  // Results
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  char_valid,
  output logic [7:0]            token_char,
  output logic                  token_last,
  output logic [LINE_W-1:0]     line_number,
  output logic [1:0]            status
);

  `include "delimiter_tokenizer_macros.svh"

  cfg_t       cfg;
  cfg_reg_t   cfg_sel;

  // Input register
  logic       s_valid, s_valid_next;
  action_t    s_action;
  logic [7:0] s_byte;
  logic       in_take;
  logic       advance;

  // Step outputs
  class_t     cls;
  logic       res_valid;
  result_t    res;

  // Result register
  logic       out_valid_next;
  result_t    out_res;

  // Configuration registers: write straight in, no read-back.
  assign cfg_sel = cfg_reg_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delimiter_set   <= DSET_W'(64'h0920);
      cfg.delimiter_count <= DCOUNT_W'(3);
      cfg.case_mode       <= CASE_KEEP;
    end else if (cfg_write) begin
      case (cfg_sel)
        REG_DELIM_SET:   cfg.delimiter_set   <= cfg_data;
        REG_DELIM_COUNT: cfg.delimiter_count <= cfg_data[DCOUNT_W-1:0];
        REG_CASE_MODE:   cfg.case_mode       <= case_mode_t'(cfg_data[1:0]);
        default:         ;
      endcase
    end
  end

  // Advance the step whenever the result register can take a word; a word
  // that yields nothing still waits for a free slot, which keeps control flat.
  assign advance  = s_valid && (!out_valid || out_ready);
  assign in_ready = !s_valid || advance;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    s_valid_next = s_valid;
    if (in_take) s_valid_next = 1'b1;
    else if (advance) s_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      s_valid <= s_valid_next;
    end
  end

  // Hold the payload of the word under work.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s_action <= action_t'(action);
      s_byte   <= data_byte;
    end
  end

  dlt_classify u_classify (
    .data_byte (s_byte),
    .cfg       (cfg),
    .cls       (cls)
  );

  dlt_step u_step (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .action    (s_action),
    .cls       (cls),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register: load on a producing step, drop once taken.
  always_comb begin
    out_valid_next = out_valid;
    if (advance && res_valid) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign char_valid  = out_res.char_valid;
  assign token_char  = out_res.token_char;
  assign token_last  = out_res.token_last;
  assign line_number = out_res.line_number;
  assign status      = out_res.status;

  // A result with no byte only reports the end of the stream.
  `DLT_ASSERT_IMP(a_empty_is_end, out_valid && !char_valid,
    status == ST_ENDED || status == ST_READ_ERR, "empty result without end status")

  // An overlong cut always closes the token on a real byte.
  `DLT_ASSERT_IMP(a_long_is_last, out_valid && status == ST_TOO_LONG,
    char_valid && token_last, "overlong status on a byte that is not last")

  // Line numbers never go backwards between results.
  `DLT_ASSERT_NXT(a_line_monotonic, out_valid && out_ready,
    !out_valid || line_number >= $past(line_number), "line number went backwards")

  // An empty result register never stalls the input side.
  `DLT_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready,
    "input stalled with empty result register")

endmodule

>>> dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dlt_pkg::*;

  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam int         DRAIN_CYCLES = 8;

  // One input word as it travels over the handshake.
  typedef struct packed {
    action_t    act;
    logic [7:0] b;
  } word_t;

  // Clock, reset and every block input start at a known value.
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_DELIM_SET;
  logic [DSET_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           action = ACT_DATA;
  logic [7:0]           data_byte = 8'd0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 char_valid;
  logic [7:0]           token_char;
  logic                 token_last;
  logic [LINE_W-1:0]    line_number;
  logic [1:0]           status;

  delimiter_tokenizer DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .char_valid  (char_valid),
    .token_char  (token_char),
    .token_last  (token_last),
    .line_number (line_number),
    .status      (status)
  );

  always #6 clk = ~clk;

  // Stimulus bookkeeping: words waiting for the driver, the word on the
  // bus, and the token words the block still owes us.
  word_t   words_to_send[$];
  word_t   in_flight;
  result_t token_words_due[$];
  logic    word_taken = 1'b0;
  int      words_queued = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      failures = 0;

  // Our copy of the configuration, written alongside the block's registers.
  logic [DSET_W-1:0]   cur_set = 64'h920;
  logic [DCOUNT_W-1:0] cur_count = 3'd3;
  case_mode_t          cur_case = CASE_KEEP;

  // Tokenizer state as we track it, starting from its reset values.
  logic [7:0]        tz_held_char = 8'd0;
  logic              tz_held_valid = 1'b0;
  int                tz_len = 0;
  logic [LINE_W-1:0] tz_line = 1;
  logic              tz_line_pending = 1'b0;
  logic              tz_skip_delay = 1'b0;
  skip_phase_t       tz_skip = SKIP_IDLE;
  logic              tz_done = 1'b0;
  logic              tz_had_token = 1'b0;

  // ---------------------------------------------------------------------
  // Token prediction
  // ---------------------------------------------------------------------

  // NUL, LF and CR always split tokens; so do the configured bytes in use.
  function automatic logic is_separator(logic [7:0] b);
    int n;
    n = int'(cur_count);
    if (n > MAX_DELIMS) n = MAX_DELIMS;
    if (b == CHR_NUL || b == CHR_LF || b == CHR_CR) return 1'b1;
    for (int i = 0; i < n; i++)
      if (cur_set[8*i +: 8] == b) return 1'b1;
    return 1'b0;
  endfunction

  // Fold ASCII letters only; any other mode leaves the byte alone.
  function automatic logic [7:0] fold_case(logic [7:0] b);
    if (cur_case == CASE_UPPER && b >= CHR_LC_A && b <= CHR_LC_Z) return b - CASE_GAP;
    if (cur_case == CASE_LOWER && b >= CHR_UC_A && b <= CHR_UC_Z) return b + CASE_GAP;
    return b;
  endfunction

  function automatic void bump_line();
    if (tz_line != '1) tz_line++;
  endfunction

  function automatic void owe_token_word(logic v, logic [7:0] ch, logic last, status_t st);
    result_t r;
    r.char_valid  = v;
    r.token_char  = ch;
    r.token_last  = last;
    r.line_number = tz_line;
    r.status      = st;
    token_words_due.push_back(r);
  endfunction

  function automatic void drop_token();
    tz_held_valid = 1'b0;
    tz_len = 0;
  endfunction

  // A new token settles any deferred line end first.
  function automatic void open_token(logic [7:0] b);
    if (tz_line_pending) begin
      bump_line();
      tz_line_pending = 1'b0;
    end
    tz_skip_delay = 1'b0;
    tz_had_token = 1'b1;
    tz_held_char = fold_case(b);
    tz_held_valid = 1'b1;
    tz_len = 1;
  endfunction

  // Advance the tracked state by one accepted word and queue what it owes.
  task automatic tokenize_word(input word_t w);
    logic full, sep, nl;
    full = (tz_len >= MAX_TOKEN);
    sep = is_separator(w.b);
    nl = (w.b == CHR_LF || w.b == CHR_CR);
    if (tz_done) return;
    case (w.act)
      ACT_END, ACT_ERROR: begin
        // Flush the held byte, if any; the stream code beats the overlong one.
        owe_token_word(tz_held_valid, tz_held_valid ? tz_held_char : 8'd0, tz_held_valid,
                       (w.act == ACT_END) ? ST_ENDED : ST_READ_ERR);
        drop_token();
        tz_done = 1'b1;
      end
      ACT_SKIP: begin
        if (tz_held_valid) begin
          owe_token_word(1'b1, tz_held_char, 1'b1, full ? ST_TOO_LONG : ST_OK);
          drop_token();
        end
        // A pending line end absorbs the first request; a second one skips.
        if (tz_skip == SKIP_IDLE) begin
          if (tz_line_pending && !tz_skip_delay) tz_skip_delay = 1'b1;
          else tz_skip = SKIP_CRLF;
        end
      end
      default: begin
        case (tz_skip)
          SKIP_CRLF: if (!nl) tz_skip = SKIP_LINE;
          SKIP_LINE: if (nl) tz_skip = SKIP_DELIM;
          SKIP_DELIM: begin
            if (!sep) begin
              bump_line();
              tz_skip = SKIP_IDLE;
              open_token(w.b);
            end
          end
          default: begin
            if (tz_held_valid) begin
              if (sep) begin
                owe_token_word(1'b1, tz_held_char, 1'b1, full ? ST_TOO_LONG : ST_OK);
                drop_token();
                if (w.b == CHR_LF) tz_line_pending = 1'b1;
              end else if (full) begin
                // Cut the overlong token here; this byte opens the next one.
                owe_token_word(1'b1, tz_held_char, 1'b1, ST_TOO_LONG);
                drop_token();
                open_token(w.b);
              end else begin
                owe_token_word(1'b1, tz_held_char, 1'b0, ST_OK);
                tz_held_char = fold_case(w.b);
                tz_len++;
              end
            end else if (sep) begin
              // Before any token an LF counts at once; afterwards it is deferred.
              if (w.b == CHR_LF) begin
                if (tz_had_token) tz_line_pending = 1'b1;
                else bump_line();
              end
            end else begin
              open_token(w.b);
            end
          end
        endcase
      end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Driver: present the next word at the falling edge, hold it until taken
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      word_taken = 1'b0;
      if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_flight = words_to_send.pop_front();
        in_valid  <= 1'b1;
        action    <= in_flight.act;
        data_byte <= in_flight.b;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: predict on every accepted word, check every accepted result
  // ---------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (in_valid && in_ready === 1'b1) begin
        word_taken = 1'b1;
        tokenize_word(in_flight);
      end
      if (out_valid === 1'b1 && out_ready) begin
        if (token_words_due.size() == 0) begin
          $error("result word arrived with nothing expected");
          failures++;
        end else begin
          want = token_words_due.pop_front();
          check_field("char_valid", want.char_valid, char_valid);
          check_field("token_char", want.token_char, token_char);
          check_field("token_last", want.token_last, token_last);
          check_field("line_number", want.line_number, line_number);
          check_field("status", want.status, status);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic void queue_word(action_t a, logic [7:0] b);
    word_t w;
    w.act = a;
    w.b = b;
    words_to_send.push_back(w);
    words_queued++;
  endfunction

  // Mostly letters so that case folding has something to do.
  function automatic logic [7:0] pick_token_byte();
    logic [7:0] b;
    do begin
      case ($urandom_range(3))
        0: b = 8'($urandom_range(CHR_LC_A, CHR_LC_Z));
        1: b = 8'($urandom_range(CHR_UC_A, CHR_UC_Z));
        default: b = 8'($urandom_range(255));
      endcase
    end while (is_separator(b));
    return b;
  endfunction

  function automatic logic [7:0] pick_separator();
    int k;
    k = $urandom_range(int'(cur_count) + 1);
    if (k < int'(cur_count)) return cur_set[8*k +: 8];
    return (k == int'(cur_count)) ? CHR_NUL : CHR_CR;
  endfunction

  // Mostly tokens, separator runs and line ends, with skips and raw noise.
  task automatic queue_random_stretch(int count);
    int stop, r, n;
    stop = words_queued + count;
    while (words_queued < stop) begin
      r = $urandom_range(99);
      if (r < 40) begin
        n = $urandom_range(1, 8);
        repeat (n) queue_word(ACT_DATA, pick_token_byte());
      end else if (r < 62) begin
        n = $urandom_range(1, 3);
        repeat (n) queue_word(ACT_DATA, pick_separator());
      end else if (r < 76) begin
        if ($urandom_range(1)) queue_word(ACT_DATA, CHR_CR);
        queue_word(ACT_DATA, CHR_LF);
      end else if (r < 88) begin
        queue_word(ACT_SKIP, 8'($urandom_range(255)));
      end else begin
        queue_word(ACT_DATA, 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic queue_long_token(int len);
    repeat (len) queue_word(ACT_DATA, pick_token_byte());
  endtask

  // Hold the sender until every owed result is in, then let the pipeline empty.
  task automatic wait_until_drained();
    while (words_to_send.size() != 0 || in_valid || token_words_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [DSET_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_DELIM_SET:   cur_set = val;
      REG_DELIM_COUNT: cur_count = val[DCOUNT_W-1:0];
      REG_CASE_MODE:   cur_case = case_mode_t'(val[1:0]);
      default: ;
    endcase
  endtask

  task automatic set_config(logic [DSET_W-1:0] set, int count, case_mode_t mode);
    write_reg(REG_DELIM_SET, set);
    write_reg(REG_DELIM_COUNT, DSET_W'(count));
    write_reg(REG_CASE_MODE, DSET_W'(mode));
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    send_idle_pct = 30;
    recv_idle_pct = 64;

    // Directed opening under the reset delimiters (space, tab, NUL).
    queue_word(ACT_DATA, CHR_LF);     // LF before any token counts at once
    queue_word(ACT_DATA, CHR_CR);     // CR never counts
    queue_word(ACT_DATA, "a");
    queue_word(ACT_DATA, "Z");
    queue_word(ACT_DATA, 8'hFF);      // top byte value as token content
    queue_word(ACT_DATA, CHR_SPACE);  // close the token
    queue_word(ACT_DATA, CHR_LF);     // defer the line end
    queue_word(ACT_DATA, CHR_LF);     // several LFs still add one
    queue_word(ACT_DATA, "b");        // line advances here
    queue_word(ACT_SKIP, 8'h00);      // close the open token, start skipping
    queue_word(ACT_DATA, CHR_LF);     // leading line end dropped
    queue_word(ACT_DATA, "x");        // rest of the line dropped
    queue_word(ACT_DATA, CHR_CR);
    queue_word(ACT_DATA, CHR_TAB);    // trailing separators dropped
    queue_word(ACT_DATA, "q");        // new token on a new line
    queue_word(ACT_DATA, CHR_LF);     // close it, line end pending
    queue_word(ACT_SKIP, 8'hFF);      // pending line end: only delay
    queue_word(ACT_SKIP, 8'h55);      // now skip for real
    queue_word(ACT_SKIP, 8'hAA);      // ignored while skipping
    queue_word(ACT_DATA, "c");
    queue_word(ACT_DATA, CHR_LF);
    queue_word(ACT_DATA, CHR_NUL);    // NUL separates too
    queue_word(ACT_DATA, "d");
    queue_word(ACT_DATA, CHR_NUL);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Random phases, each under a fresh setting written while idle.
    for (int phase = 1; phase <= 6; phase++) begin
      wait_until_drained();
      case (phase)
        1: set_config({$urandom, $urandom}, 7, CASE_UPPER);
        2: set_config('0, 0, CASE_LOWER);
        3: set_config('1, 7, CASE_KEEP);
        4: set_config(64'h0920_2F2D_2E3A_3B2C, $urandom_range(1, 6), CASE_UPPER);
        5: set_config({$urandom, $urandom}, $urandom_range(7), CASE_LOWER);
        default: set_config(64'h920, 3, case_mode_t'($urandom_range(2)));
      endcase
      // Receiver slow first, then the sender, then both flat out.
      if (phase <= 2) begin
        send_idle_pct = 30;
        recv_idle_pct = 64;
      end else if (phase <= 4) begin
        send_idle_pct = 64;
        recv_idle_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // Overlong tokens: one cut exactly at the limit by a skip, one twice the
      // limit so it is cut by a token byte and then by a separator.
      if (phase == 2) begin
        queue_long_token(MAX_TOKEN);
        queue_word(ACT_SKIP, 8'($urandom_range(255)));
      end else if (phase == 4) begin
        queue_long_token(2 * MAX_TOKEN);
        queue_word(ACT_DATA, pick_separator());
      end
      queue_random_stretch(40);
    end

    // Close the stream one way or the other, then check that it stays shut.
    queue_word($urandom_range(1) ? ACT_END : ACT_ERROR, 8'($urandom_range(255)));
    queue_word(ACT_DATA, "a");
    queue_word(ACT_SKIP, 8'($urandom_range(255)));
    queue_word(ACT_END, 8'($urandom_range(255)));
    queue_word(ACT_ERROR, 8'($urandom_range(255)));
    queue_word(ACT_DATA, CHR_LF);

    wait_until_drained();
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
